// ===== hw/rtl/rrqq_pkg.sv =====
// Package with the shared types and codes of the round-robin quantum queue.
package rrqq_pkg;

    localparam logic [1:0] MODE_ADD      = 2'd0;
    localparam logic [1:0] MODE_DISPATCH = 2'd1;
    localparam logic [1:0] MODE_AVERAGE  = 2'd2;

    localparam logic [2:0] STATUS_REQUEUED = 3'd0;
    localparam logic [2:0] STATUS_FINISHED = 3'd1;
    localparam logic [2:0] STATUS_EMPTY    = 3'd2;
    localparam logic [2:0] STATUS_AVERAGE  = 3'd3;
    localparam logic [2:0] STATUS_OVERFLOW = 3'd4;
    localparam logic [2:0] STATUS_BADMODE  = 3'd5;

    localparam logic [23:0] MEAN_MAX = 24'hFF_FFFF;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] burst;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] run_time;
        logic [23:0] mean_value;
        logic [6:0]  jobs_left;
    } result_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_DISPATCH,
        OP_AVERAGE,
        OP_BADMODE
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [15:0] burst;
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DISPATCH,
        BK_DIVIDE
    } back_state_t;

endpackage

// ===== hw/rtl/rrqq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module rrqq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/rrqq_div.sv =====
// Restoring unsigned divider that produces one quotient bit per cycle.
module rrqq_div #(
    parameter int DVD_W = 30,
    parameter int DSR_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(DVD_W);
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (run_reg)
        begin
            quo_next = {quo_reg[DVD_W-2:0], ge};
            rem_next = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/rrqq_front.sv =====
// Front end: accepts commands, classifies them and holds them in a two-entry queue.
module rrqq_front #(
    parameter int BURST_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  rrqq_pkg::cmd_t       cmd,
    output logic                 op_valid,
    output rrqq_pkg::op_t        op,
    input  logic                 op_pop
);

    rrqq_pkg::op_t              entry_reg [2];
    logic                       wr_ptr_reg, wr_ptr_next;
    logic                       rd_ptr_reg, rd_ptr_next;
    logic [1:0]                 fill_reg, fill_next;
    logic                       accept;
    logic                       push;
    logic [BURST_BITS+15:0]     burst_wide;
    rrqq_pkg::op_t              new_op;

    assign busy       = (fill_reg == 2'd2);
    assign accept     = start && !busy;
    assign burst_wide = (BURST_BITS + 16)'(cmd.burst);

    always_comb
    begin
        new_op.burst = cmd.burst;
        unique case (cmd.mode)
            rrqq_pkg::MODE_ADD:      new_op.kind = rrqq_pkg::OP_ADD;
            rrqq_pkg::MODE_DISPATCH: new_op.kind = rrqq_pkg::OP_DISPATCH;
            rrqq_pkg::MODE_AVERAGE:  new_op.kind = rrqq_pkg::OP_AVERAGE;
            default:                 new_op.kind = rrqq_pkg::OP_BADMODE;
        endcase
    end

    // An add of a zero burst changes nothing and reports nothing, so it is dropped here.
    assign push = accept &&
                  !((new_op.kind == rrqq_pkg::OP_ADD) && (burst_wide[BURST_BITS-1:0] == '0));

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = op_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(op_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_op;
        end
    end

    assign op_valid = (fill_reg != 2'd0);
    assign op       = entry_reg[rd_ptr_reg];

endmodule

// ===== hw/rtl/rrqq_back.sv =====
// Back end: job ring, running sum, quantum register and result generation.
module rrqq_back #(
    parameter int QUEUE_DEPTH = 64,
    parameter int BURST_BITS  = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 op_valid,
    input  rrqq_pkg::op_t        op,
    output logic                 op_pop,
    input  logic                 quantum_we,
    input  logic [15:0]          quantum_data,
    output logic                 result_valid,
    output rrqq_pkg::result_t    result
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = BURST_BITS + CNT_W;
    localparam int DVD_W = SUM_W + 8;
    localparam int WIDE  = BURST_BITS + 16;

    rrqq_pkg::back_state_t state_reg, state_next;

    logic [PTR_W-1:0]      head_reg, head_next;
    logic [PTR_W-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [15:0]           quantum_reg;
    logic                  res_valid_reg, res_valid_next;
    rrqq_pkg::result_t     res_reg, res_next;

    logic                  ram_we;
    logic [BURST_BITS-1:0] ram_wdata;
    logic [BURST_BITS-1:0] ram_rdata;
    logic                  div_start;
    logic                  div_done;
    logic [DVD_W-1:0]      div_quo;
    logic [DVD_W+23:0]     quo_wide;
    logic [23:0]           mean;

    logic [WIDE-1:0]       burst_wide;
    logic [WIDE-1:0]       job_wide;
    logic [WIDE-1:0]       quantum_wide;
    logic [WIDE-1:0]       remain_wide;
    logic [CNT_W+6:0]      count_wide;
    logic [CNT_W+6:0]      count_dec_wide;
    logic [PTR_W-1:0]      head_inc;
    logic [PTR_W-1:0]      tail_inc;
    logic                  full;
    logic                  empty;
    logic                  longer;

    rrqq_ram #(
        .WIDTH (BURST_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_job_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (ram_wdata),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    rrqq_div #(
        .DVD_W (DVD_W),
        .DSR_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({sum_reg, 8'd0}),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign burst_wide     = WIDE'(op.burst);
    assign job_wide       = WIDE'(ram_rdata);
    assign quantum_wide   = WIDE'(quantum_reg);
    assign remain_wide    = job_wide - quantum_wide;
    assign longer         = (job_wide > quantum_wide);
    assign count_wide     = (CNT_W + 7)'(count_reg);
    assign count_dec_wide = (CNT_W + 7)'(count_reg - CNT_W'(1));
    assign head_inc       = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
    assign tail_inc       = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + PTR_W'(1);
    assign full           = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty          = (count_reg == '0);
    assign quo_wide       = (DVD_W + 24)'(div_quo);
    assign mean           = (quo_wide[DVD_W+23:24] != '0) ? rrqq_pkg::MEAN_MAX : quo_wide[23:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rrqq_pkg::BK_IDLE:
            begin
                if (op_valid && !empty)
                begin
                    if (op.kind == rrqq_pkg::OP_DISPATCH)
                    begin
                        state_next = rrqq_pkg::BK_DISPATCH;
                    end
                    else if (op.kind == rrqq_pkg::OP_AVERAGE)
                    begin
                        state_next = rrqq_pkg::BK_DIVIDE;
                    end
                end
            end
            rrqq_pkg::BK_DISPATCH:
            begin
                state_next = rrqq_pkg::BK_IDLE;
            end
            rrqq_pkg::BK_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = rrqq_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = rrqq_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        op_pop         = 1'b0;
        ram_we         = 1'b0;
        ram_wdata      = burst_wide[BURST_BITS-1:0];
        div_start      = 1'b0;
        res_valid_next = 1'b0;
        res_next       = '0;
        res_next.jobs_left = count_wide[6:0];
        unique case (state_reg)
            rrqq_pkg::BK_IDLE:
            begin
                if (op_valid)
                begin
                    op_pop = 1'b1;
                    unique case (op.kind)
                        rrqq_pkg::OP_ADD:
                        begin
                            if (full)
                            begin
                                res_valid_next  = 1'b1;
                                res_next.status = rrqq_pkg::STATUS_OVERFLOW;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                tail_next  = tail_inc;
                                count_next = count_reg + CNT_W'(1);
                                sum_next   = sum_reg + SUM_W'(burst_wide[BURST_BITS-1:0]);
                            end
                        end
                        rrqq_pkg::OP_DISPATCH:
                        begin
                            if (empty)
                            begin
                                res_valid_next  = 1'b1;
                                res_next.status = rrqq_pkg::STATUS_EMPTY;
                            end
                        end
                        rrqq_pkg::OP_AVERAGE:
                        begin
                            if (empty)
                            begin
                                res_valid_next  = 1'b1;
                                res_next.status = rrqq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                div_start = 1'b1;
                            end
                        end
                        default:
                        begin
                            res_valid_next  = 1'b1;
                            res_next.status = rrqq_pkg::STATUS_BADMODE;
                        end
                    endcase
                end
            end
            rrqq_pkg::BK_DISPATCH:
            begin
                res_valid_next = 1'b1;
                head_next      = head_inc;
                if (longer)
                begin
                    // The job keeps its place in the count and returns to the tail.
                    ram_we            = 1'b1;
                    ram_wdata         = remain_wide[BURST_BITS-1:0];
                    tail_next         = tail_inc;
                    sum_next          = sum_reg - quantum_wide[SUM_W-1:0];
                    res_next.status   = rrqq_pkg::STATUS_REQUEUED;
                    res_next.run_time = quantum_reg;
                end
                else
                begin
                    count_next         = count_reg - CNT_W'(1);
                    sum_next           = sum_reg - SUM_W'(ram_rdata);
                    res_next.status    = rrqq_pkg::STATUS_FINISHED;
                    res_next.run_time  = job_wide[15:0];
                    res_next.jobs_left = count_dec_wide[6:0];
                end
            end
            rrqq_pkg::BK_DIVIDE:
            begin
                if (div_done)
                begin
                    res_valid_next      = 1'b1;
                    res_next.status     = rrqq_pkg::STATUS_AVERAGE;
                    res_next.mean_value = mean;
                end
            end
            default:
            begin
                res_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rrqq_pkg::BK_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            quantum_reg   <= 16'd1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            res_valid_reg <= res_valid_next;
            if (quantum_we)
            begin
                quantum_reg <= quantum_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ===== hw/rtl/round_robin_quantum_queue.sv =====
// Top level of the round-robin quantum queue: front end, command queue and back end.
//
//  Channel        Ports                        Transfer
//  command in     start, busy, cmd             start high while busy is low
//  quantum write  quantum_we, quantum_data     quantum_we high
//  result out     result_valid, result         one-cycle strobe, always taken
//
// An add is handled in the back end's idle state, and a dispatch passes through the idle
// and dispatch states (ring read, then compare and write-back through the single RAM
// write port). An average query runs the restoring divider over a dividend of
// BURST_BITS + clog2(QUEUE_DEPTH+1) + 8 bits. Results are registered in the back end.
// Reset clears the ring pointers, job count, sum and queue and sets the quantum to 1.
// busy rises when the two-entry command queue is full; results cannot be stalled.
module round_robin_quantum_queue #(
    parameter int QUEUE_DEPTH = 64,
    parameter int BURST_BITS  = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  rrqq_pkg::cmd_t    cmd,
    input  logic              quantum_we,
    input  logic [15:0]       quantum_data,
    output logic              result_valid,
    output rrqq_pkg::result_t result
);

    logic          op_valid;
    logic          op_pop;
    rrqq_pkg::op_t op;

    rrqq_front #(
        .BURST_BITS (BURST_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .op_valid (op_valid),
        .op       (op),
        .op_pop   (op_pop)
    );

    rrqq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .BURST_BITS  (BURST_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (op_valid),
        .op           (op),
        .op_pop       (op_pop),
        .quantum_we   (quantum_we),
        .quantum_data (quantum_data),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
